FILE: hw/rtl/isfw_pkg.sv
// Shared constants and types for the interlaced sync to framebuffer writer.
package isfw_pkg;

  // Framebuffer geometry
  localparam int unsigned SCREEN_WIDTH  = 1024;
  localparam int unsigned SCREEN_HEIGHT = 768;

  // Field and counter widths
  localparam int unsigned WARM_W   = 19;
  localparam int unsigned COLOUR_W = 24;
  localparam int unsigned BEAM_W   = 11;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned CMP_W    = BEAM_W + 2;

  // Stream widths (packed fields rounded up to whole bytes)
  localparam int unsigned IN_FIELDS_W  = 3 + COLOUR_W;
  localparam int unsigned IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = 1 + POS_W + POS_W + COLOUR_W + 1;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Colour constants
  localparam logic [COLOUR_W-1:0] GREY  = 24'h808080;
  localparam logic [COLOUR_W-1:0] RED   = 24'hff0000;
  localparam logic [COLOUR_W-1:0] GREEN = 24'h00ff00;

  localparam logic [BEAM_W-1:0] ROW_STEP   = BEAM_W'(2);
  localparam logic [BEAM_W-1:0] COL_MAX    = {BEAM_W{1'b1}};
  localparam logic [WARM_W-1:0] WARM_RESET = WARM_W'(262140);

  // Bounds as wide compare values (height signed, width unsigned)
  localparam logic signed [CMP_W-1:0] HEIGHT_CMP = CMP_W'(SCREEN_HEIGHT);
  localparam logic [BEAM_W:0]         WIDTH_CMP  = (BEAM_W + 1)'(SCREEN_WIDTH);

  // One result item
  typedef struct packed {
    logic                frame_done;
    logic [COLOUR_W-1:0] colour;
    logic [POS_W-1:0]    row;
    logic [POS_W-1:0]    column;
    logic                write_valid;
  } result_t;

endpackage

FILE: hw/rtl/interlaced_sync_to_framebuffer_writer_top.sv
// Interlaced sync to framebuffer writer: beam tracking and pixel write generation.
// Each accepted input transaction leaves its result in the output register.
// Throughput: one transaction per cycle while the output is not stalled; while
// drawing, the beam counters and sync edge detectors update in the accepting cycle.
// Reset (rst_n, synchronous): warm-up counter loads 262140, beam at (0,0),
// even field, sync history cleared, output register empty.
module interlaced_sync_to_framebuffer_writer_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration: warm_up_ticks
  input  logic                                 cfg_wr_en,
  input  logic [isfw_pkg::WARM_W-1:0]          cfg_wr_data,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // tdata: hsync, vsync, active video flag, video_colour[23:0] (LSB first)
  input  logic [isfw_pkg::IN_DATA_W-1:0]       in_tdata,
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // tdata: write_valid, column[9:0], row[9:0], colour[23:0], frame_done (LSB first)
  output logic [isfw_pkg::OUT_DATA_W-1:0]      out_tdata
);

  // State registers
  logic [isfw_pkg::WARM_W-1:0]   warm_up_r,  warm_up_nxt;
  logic [isfw_pkg::WARM_W-1:0]   warm_cnt_r, warm_cnt_nxt;
  logic                          drawing_r,  drawing_nxt;
  logic [isfw_pkg::BEAM_W-1:0]   col_r,      col_nxt;
  logic [isfw_pkg::BEAM_W-1:0]   row_r,      row_nxt;
  logic                          even_r,     even_nxt;
  logic                          phs_r,      phs_nxt;
  logic                          pvs_r,      pvs_nxt;
  logic                          ovalid_r,   ovalid_nxt;
  isfw_pkg::result_t             res_r,      res_nxt;

  logic                          accept;
  logic                          hs, vs, de;
  logic [isfw_pkg::COLOUR_W-1:0] vcol;
  logic [isfw_pkg::COLOUR_W-1:0] pix;
  logic                          on_screen;
  logic [isfw_pkg::BEAM_W-1:0]   col_a, row_a;
  logic                          even_a, done_a;

  // Input unpacking
  assign hs   = in_tdata[0];
  assign vs   = in_tdata[1];
  assign de   = in_tdata[2];
  assign vcol = in_tdata[3 +: isfw_pkg::COLOUR_W];

  // Output register frees up when empty or being drained
  assign in_tready  = !ovalid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = isfw_pkg::OUT_DATA_W'(res_r);

  // Pixel colour
  always_comb begin
    pix = isfw_pkg::GREY;
    if (vs) pix = pix | isfw_pkg::RED;
    if (hs) pix = pix | isfw_pkg::GREEN;
    if (!hs && !vs && de) pix = vcol;
  end

  // Current beam inside the framebuffer
  assign on_screen = !row_r[isfw_pkg::BEAM_W-1] &&
                     ($signed({2'b00, row_r}) < isfw_pkg::HEIGHT_CMP) &&
                     ({1'b0, col_r} < isfw_pkg::WIDTH_CMP);

  // Beam update for a drawing transaction
  always_comb begin
    col_a  = (col_r != isfw_pkg::COL_MAX) ? col_r + 1'b1 : col_r;
    row_a  = row_r;
    even_a = even_r;
    done_a = 1'b0;
    // hsync rising edge: next line pair
    if (hs && !phs_r) begin
      col_a = '0;
      row_a = row_r + isfw_pkg::ROW_STEP;
    end
    // vsync rising edge: alternate fields
    if (vs && !pvs_r) begin
      if (even_r) begin
        col_a = '0;
        row_a = '1;
      end else begin
        row_a = '0;
      end
      even_a = !even_r;
      done_a = 1'b1;
    end
    // bottom of the frame
    if ($signed({{2{row_a[isfw_pkg::BEAM_W-1]}}, row_a}) >= isfw_pkg::HEIGHT_CMP) begin
      col_a  = '0;
      row_a  = '0;
      even_a = 1'b1;
      done_a = 1'b1;
    end
  end

  // Next state and result
  always_comb begin
    warm_up_nxt  = warm_up_r;
    warm_cnt_nxt = warm_cnt_r;
    drawing_nxt  = drawing_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    even_nxt     = even_r;
    phs_nxt      = phs_r;
    pvs_nxt      = pvs_r;
    ovalid_nxt   = ovalid_r && !out_tready;
    res_nxt      = res_r;
    if (accept) begin
      ovalid_nxt = 1'b1;
      res_nxt    = '0;
      if (!drawing_r) begin
        // warm-up: count down, no write
        if (warm_cnt_r == '0) drawing_nxt = 1'b1;
        else                  warm_cnt_nxt = warm_cnt_r - 1'b1;
      end else begin
        if (on_screen) begin
          res_nxt.write_valid = 1'b1;
          res_nxt.column      = col_r[isfw_pkg::POS_W-1:0];
          res_nxt.row         = row_r[isfw_pkg::POS_W-1:0];
          res_nxt.colour      = pix;
        end
        res_nxt.frame_done = done_a;
        col_nxt  = col_a;
        row_nxt  = row_a;
        even_nxt = even_a;
        phs_nxt  = hs;
        pvs_nxt  = vs;
      end
    end
    // configuration write restarts warm-up while not drawing
    if (cfg_wr_en) begin
      warm_up_nxt = cfg_wr_data;
      if (!drawing_r) warm_cnt_nxt = cfg_wr_data;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_up_r  <= isfw_pkg::WARM_RESET;
      warm_cnt_r <= isfw_pkg::WARM_RESET;
      drawing_r  <= 1'b0;
      col_r      <= '0;
      row_r      <= '0;
      even_r     <= 1'b1;
      phs_r      <= 1'b0;
      pvs_r      <= 1'b0;
      ovalid_r   <= 1'b0;
    end else begin
      warm_up_r  <= warm_up_nxt;
      warm_cnt_r <= warm_cnt_nxt;
      drawing_r  <= drawing_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      even_r     <= even_nxt;
      phs_r      <= phs_nxt;
      pvs_r      <= pvs_nxt;
      ovalid_r   <= ovalid_nxt;
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

FILE: bench/interlaced_sync_to_framebuffer_writer_top_tb.sv
// Testbench for the interlaced sync to framebuffer writer: beam model, stream drivers, checker.
module interlaced_sync_to_framebuffer_writer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TOTAL_PIXELS = 1900;
  localparam int unsigned LONG_LINE_TICKS = 1030;
  localparam int unsigned TALL_LINES = 390;
  localparam int unsigned MAX_REPORTS = 10;

  logic                              clk;
  logic                              rst_n;
  logic                              cfg_wr_en;
  logic [isfw_pkg::WARM_W-1:0]       cfg_wr_data;
  logic                              in_tvalid;
  logic                              in_tready;
  logic [isfw_pkg::IN_DATA_W-1:0]    in_tdata;
  logic                              out_tvalid;
  logic                              out_tready;
  logic [isfw_pkg::OUT_DATA_W-1:0]   out_tdata;

  // Idle controls for the sender and the receiver, and a count of sent pixels
  bit          src_gaps = 1'b1;
  bit          sink_gaps = 1'b1;
  int unsigned sink_hold = 0;
  int unsigned pixels_sent = 0;

  // Expected framebuffer writes, oldest first
  isfw_pkg::result_t pending_writes[$];
  int unsigned       bad_writes = 0;

  // Beam model state
  logic [isfw_pkg::WARM_W-1:0] bm_warm_left = isfw_pkg::WARM_RESET;
  logic                        bm_drawing = 1'b0;
  logic [isfw_pkg::BEAM_W-1:0] bm_col = '0;
  logic [isfw_pkg::BEAM_W-1:0] bm_row = '0;
  logic                        bm_even = 1'b1;
  logic                        bm_prev_hs = 1'b0;
  logic                        bm_prev_vs = 1'b0;

  interlaced_sync_to_framebuffer_writer_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Advance the beam by one pixel tick and return the write it issues
  function automatic isfw_pkg::result_t predict_pixel_write(
      input logic hs, input logic vs, input logic de,
      input logic [isfw_pkg::COLOUR_W-1:0] rgb);
    isfw_pkg::result_t             w;
    logic [isfw_pkg::COLOUR_W-1:0] shade;
    int                            row_i;
    w = '0;
    if (!bm_drawing) begin
      if (bm_warm_left == '0) begin
        bm_drawing = 1'b1;
      end else begin
        bm_warm_left = bm_warm_left - 1'b1;
      end
      return w;
    end
    shade = isfw_pkg::GREY;
    if (vs) shade = shade | isfw_pkg::RED;
    if (hs) shade = shade | isfw_pkg::GREEN;
    if (!hs && !vs && de) shade = rgb;
    row_i = int'($signed(bm_row));
    if (row_i >= 0 && row_i < int'(isfw_pkg::SCREEN_HEIGHT) &&
        bm_col < isfw_pkg::SCREEN_WIDTH) begin
      w.write_valid = 1'b1;
      w.column      = bm_col[isfw_pkg::POS_W-1:0];
      w.row         = bm_row[isfw_pkg::POS_W-1:0];
      w.colour      = shade;
    end
    if (bm_col != isfw_pkg::COL_MAX) bm_col = bm_col + 1'b1;
    // hsync rising edge: next line of this field
    if (hs && !bm_prev_hs) begin
      bm_col = '0;
      bm_row = bm_row + isfw_pkg::ROW_STEP;
    end
    // vsync rising edge: toggle field, odd field starts one row up
    if (vs && !bm_prev_vs) begin
      if (bm_even) begin
        bm_col = '0;
        bm_row = '1;
      end else begin
        bm_row = '0;
      end
      bm_even = ~bm_even;
      w.frame_done = 1'b1;
    end
    // bottom of the screen ends the frame
    if (int'($signed(bm_row)) >= int'(isfw_pkg::SCREEN_HEIGHT)) begin
      bm_col = '0;
      bm_row = '0;
      bm_even = 1'b1;
      w.frame_done = 1'b1;
    end
    bm_prev_hs = hs;
    bm_prev_vs = vs;
    return w;
  endfunction

  // Track register writes, check results, predict each accepted transaction
  always @(posedge clk) begin : check_and_predict
    isfw_pkg::result_t got;
    isfw_pkg::result_t want;
    if (rst_n) begin
      if (cfg_wr_en) begin
        if (!bm_drawing) bm_warm_left = cfg_wr_data;
      end
      if (out_tvalid && out_tready) begin
        got = isfw_pkg::result_t'(out_tdata[isfw_pkg::OUT_FIELDS_W-1:0]);
        if (pending_writes.size() == 0) begin
          if (bad_writes < MAX_REPORTS)
            $display("unexpected result transaction: %h", out_tdata);
          bad_writes++;
        end else begin
          want = pending_writes.pop_front();
          if (got.write_valid !== want.write_valid || got.column !== want.column ||
              got.row !== want.row || got.colour !== want.colour ||
              got.frame_done !== want.frame_done) begin
            if (bad_writes < MAX_REPORTS)
              $display({"write mismatch: exp wv=%0d col=%0d row=%0d rgb=%06h done=%0d,",
                        " got wv=%0d col=%0d row=%0d rgb=%06h done=%0d"},
                       want.write_valid, want.column, want.row, want.colour,
                       want.frame_done, got.write_valid, got.column, got.row,
                       got.colour, got.frame_done);
            bad_writes++;
          end
        end
      end
      if (in_tvalid && in_tready)
        pending_writes.push_back(predict_pixel_write(in_tdata[0], in_tdata[1], in_tdata[2],
                                                     in_tdata[3 +: isfw_pkg::COLOUR_W]));
    end
  end

  // Result receiver: random stalls, plus long hold-offs on request
  initial begin : result_sink
    int unsigned stall;
    out_tready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (sink_hold > 0) begin
        stall = sink_hold;
        sink_hold = 0;
      end else begin
        stall = sink_gaps ? $urandom_range(0, 8) : 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // One pixel tick transaction; tvalid stays high when the next follows at once
  task automatic send_pixel(input logic hs, input logic vs, input logic de,
                            input logic [isfw_pkg::COLOUR_W-1:0] rgb);
    int unsigned gap;
    gap = src_gaps ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= isfw_pkg::IN_DATA_W'({rgb, de, vs, hs});
    do @(posedge clk); while (!in_tready);
    pixels_sent++;
  endtask

  // Well-formed sync levels with random content, occasionally pure noise
  task automatic send_video(input bit noisy, input logic hs, input logic vs);
    logic [2:0] junk;
    if (noisy && $urandom_range(0, 11) == 0) begin
      junk = 3'($urandom);
      send_pixel(junk[0], junk[1], junk[2], isfw_pkg::COLOUR_W'($urandom));
    end else begin
      send_pixel(hs, vs, $urandom_range(0, 7) != 0, isfw_pkg::COLOUR_W'($urandom));
    end
  endtask

  // vsync pulse followed by lines of hsync pulse plus active pixels
  task automatic send_frame(input bit noisy, input int unsigned n_lines,
                            input int unsigned max_active);
    int unsigned active;
    repeat ($urandom_range(1, 3)) send_video(noisy, 1'b0, 1'b1);
    repeat (n_lines) begin
      active = $urandom_range(1, max_active);
      repeat ($urandom_range(1, 2)) send_video(noisy, 1'b1, 1'b0);
      repeat (active) send_video(noisy, 1'b0, 1'b0);
    end
  endtask

  // Register write once the block has drained
  task automatic set_warm_up(input logic [isfw_pkg::WARM_W-1:0] ticks);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_writes.size() != 0);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ticks;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Reset warm-up length, longest warm-up, then a short one run to completion
  task automatic test_warm_up();
    repeat (3) send_pixel(1'b0, 1'b0, 1'b1, isfw_pkg::COLOUR_W'($urandom));
    set_warm_up('1);
    repeat (3) send_pixel(1'b1, 1'b1, 1'b1, isfw_pkg::COLOUR_W'($urandom));
    set_warm_up(isfw_pkg::WARM_W'(6));
    repeat (9) send_pixel(1'b0, 1'b0, 1'b1, isfw_pkg::COLOUR_W'($urandom));
  endtask

  // Colour selection and sync edge handling in both fields
  task automatic test_colour_and_sync();
    send_pixel(1'b0, 1'b0, 1'b1, '1);
    send_pixel(1'b0, 1'b0, 1'b1, '0);
    send_pixel(1'b0, 1'b0, 1'b0, isfw_pkg::COLOUR_W'($urandom));
    send_pixel(1'b1, 1'b0, 1'b1, isfw_pkg::COLOUR_W'($urandom));
    send_pixel(1'b0, 1'b0, 1'b1, isfw_pkg::COLOUR_W'($urandom));
    // odd field start: row above the screen, write suppressed
    send_pixel(1'b0, 1'b1, 1'b1, isfw_pkg::COLOUR_W'($urandom));
    send_pixel(1'b0, 1'b0, 1'b1, isfw_pkg::COLOUR_W'($urandom));
    send_pixel(1'b1, 1'b1, 1'b1, isfw_pkg::COLOUR_W'($urandom));
    send_pixel(1'b0, 1'b0, 1'b1, isfw_pkg::COLOUR_W'($urandom));
    // odd field start again: row above the screen, column cleared
    send_pixel(1'b0, 1'b1, 1'b0, isfw_pkg::COLOUR_W'($urandom));
    send_pixel(1'b0, 1'b0, 1'b1, isfw_pkg::COLOUR_W'($urandom));
    // both sync edges in one tick
    send_pixel(1'b1, 1'b1, 1'b1, isfw_pkg::COLOUR_W'($urandom));
    send_pixel(1'b0, 1'b0, 1'b1, isfw_pkg::COLOUR_W'($urandom));
  endtask

  // Register writes after drawing has started change nothing visible
  task automatic test_config_while_drawing();
    set_warm_up('0);
    repeat (3) send_video(1'b1, 1'b0, 1'b0);
    set_warm_up('1);
    repeat (3) send_video(1'b1, 1'b0, 1'b0);
  endtask

  // One line long enough to run off the right edge
  task automatic test_long_line();
    src_gaps  = 1'b0;
    sink_gaps = 1'b1;
    repeat (LONG_LINE_TICKS)
      send_pixel(1'b0, 1'b0, 1'($urandom_range(0, 1)), isfw_pkg::COLOUR_W'($urandom));
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    src_gaps  = 1'b0;
    sink_hold = 64;
    send_frame(1'b1, 4, 8);
  endtask

  // Random video: one tall field down to the bottom, then short noisy frames
  task automatic test_video_frames();
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    repeat ($urandom_range(1, 3)) send_video(1'b0, 1'b0, 1'b1);
    repeat (TALL_LINES) begin
      send_video(1'b0, 1'b1, 1'b0);
      send_video(1'b0, 1'b0, 1'b0);
    end
    while (pixels_sent < TOTAL_PIXELS) begin
      src_gaps  = $urandom_range(0, 3) != 0;
      sink_gaps = $urandom_range(0, 3) != 0;
      send_frame(1'b1, $urandom_range(1, 8), $urandom_range(1, 6));
    end
  endtask

  initial begin : main
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_warm_up();
    test_colour_and_sync();
    test_config_while_drawing();
    test_long_line();
    test_backpressure();
    test_video_frames();
    in_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (bad_writes == 0 && pending_writes.size() == 0) begin
      $display("interlaced_sync_to_framebuffer_writer_top_tb OK");
    end else begin
      $display("interlaced_sync_to_framebuffer_writer_top_tb NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(5_000_000);
    $display("interlaced_sync_to_framebuffer_writer_top_tb NOT OK");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/isfw_pkg.sv
hw/rtl/interlaced_sync_to_framebuffer_writer_top.sv
bench/interlaced_sync_to_framebuffer_writer_top_tb.sv
